[sv/assert_macros.svh]
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[sv/clwc_pkg.sv]
package clwc_pkg;

    localparam int PASS_LEN_DEFAULT = 8;

    localparam int MAX_WRONG_W  = 3;
    localparam int IDLE_LIMIT_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [MAX_WRONG_W-1:0]  MAX_WRONG_RESET  = 3'd3;
    localparam logic [IDLE_LIMIT_W-1:0] IDLE_LIMIT_RESET = 16'd2000;

    localparam logic [11:0] FLASH_SHORT = 12'd250;
    localparam logic [11:0] FLASH_MID   = 12'd1000;
    localparam logic [11:0] FLASH_LONG  = 12'd2500;
    localparam logic [11:0] FLASH_NONE  = 12'd0;

    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_Y    = 8'h79;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_WRONG  = 1'b0,
        CFG_IDLE_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_GOOD    = 4'd1,
        EV_WRONG   = 4'd2,
        EV_LOCKOUT = 4'd3,
        EV_UNLOCK  = 4'd4,
        EV_IDLE    = 4'd5,
        EV_CHSTART = 4'd6,
        EV_STORED  = 4'd7,
        EV_ASK     = 4'd8,
        EV_CHANGED = 4'd9,
        EV_KEPT    = 4'd10
    } event_t;

    typedef enum logic [1:0] {
        LAMP_NONE   = 2'd0,
        LAMP_GREEN  = 2'd1,
        LAMP_YELLOW = 2'd2,
        LAMP_RED    = 2'd3
    } lamp_t;

    typedef enum logic [1:0] {
        PH_NORMAL  = 2'd0,
        PH_ENTER   = 2'd1,
        PH_CONFIRM = 2'd2
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        event_t      event_res;
        lamp_t       led;
        logic [11:0] flash_ms;
        logic [2:0]  position;
        logic [2:0]  strikes;
        phase_t      phase_out;
    } result_t;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_wr_t;

    // Factory password, zero beyond its eighth letter.
    function automatic logic [7:0] default_char(input int unsigned idx);
        logic [7:0] ch;
        case (idx)
            0: ch = 8'h61;
            1: ch = 8'h73;
            2: ch = 8'h64;
            3: ch = 8'h66;
            4: ch = 8'h67;
            5: ch = 8'h68;
            6: ch = 8'h6A;
            7: ch = 8'h6B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[sv/code_lock_with_change.sv]
// Code lock over a stream of received characters and millisecond ticks. Each input
// transaction carries either one character (s_tuser low, code in s_tdata) or one tick
// (s_tuser high) and yields exactly one result transaction reporting the event, the
// lamp to flash and its length, and the match position, strike count and phase after
// the item. Letters are case-folded and checked against the stored password; '+'
// starts a password change that ends on CR or LF (or a full buffer) and is then
// confirmed with 'y' or dropped with 'n'. The block takes one transaction per clock
// cycle while m_tready stays high. A transaction is held in the input register,
// where the whole state update is worked out, and is then loaded into the result
// register, whose contents are offered on m_tvalid. s_tready falls only while both
// registers are full and m_tready is low. Write max_wrong and idle_limit only while idle.
`include "assert_macros.svh"

module code_lock_with_change #(
    parameter int PASS_LEN = clwc_pkg::PASS_LEN_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] byte_value
    input  logic                            s_tuser,  // [0] mode
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] event_res, [5:4] led, [17:6] flash_ms, [20:18] position,
    // [23:21] strikes, [25:24] phase_out, [31:26] zero
    output logic [31:0]                     m_tdata,
    // Configuration write port: index 0 max_wrong, index 1 idle_limit.
    input  logic                            cfg_wr_en,
    input  logic [clwc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [clwc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    clwc_pkg::in_item_t s_item;
    clwc_pkg::in_item_t item;
    clwc_pkg::result_t  result;
    clwc_pkg::result_t  m_result;
    clwc_pkg::cfg_wr_t  cfg;
    logic               fire;
    logic               out_ready;
    logic               quiet_lamp;
    logic               quiet_flash;
    logic               ends_entry;
    logic               no_progress;

    assign s_item.mode       = s_tuser;
    assign s_item.byte_value = s_tdata;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.addr  = cfg_addr;
    assign cfg.wdata = cfg_wdata;

    // The input register hands its transaction on whenever the result register can
    // take a new one, so the input side only stalls while both registers are full.
    clwc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .down_ready (out_ready),
        .fire       (fire),
        .item       (item)
    );

    // The lock state advances exactly on the cycles in which a transaction moves on.
    clwc_core #(
        .PASS_LEN (PASS_LEN)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (fire),
        .item    (item),
        .result  (result)
    );

    clwc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .up_ready (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {6'b0, m_result.phase_out, m_result.strikes, m_result.position,
                      m_result.flash_ms, m_result.led, m_result.event_res};

    assign quiet_lamp  = (result.led == clwc_pkg::LAMP_NONE);
    assign quiet_flash = (result.flash_ms == clwc_pkg::FLASH_NONE);
    assign ends_entry  = (result.event_res == clwc_pkg::EV_UNLOCK)
                      || (result.event_res == clwc_pkg::EV_LOCKOUT);
    assign no_progress = (result.position == 3'd0) && (result.strikes == 3'd0);

    // With an empty result register the input side must never stall.
    `ASSERT_CLK(a_ready_when_out_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

    // Events without a lamp must not flash.
    `ASSERT_CLK(a_quiet_event, fire && quiet_lamp |-> quiet_flash, "flash without lamp")

    // Unlock and lockout both clear progress.
    `ASSERT_CLK(a_progress_cleared, fire && ends_entry |-> no_progress, "progress kept")

    // Reset empties the result register.
    `ASSERT_CLK_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

[sv/clwc_in_stage.sv]
module clwc_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  clwc_pkg::in_item_t s_item,
    input  logic               down_ready,
    output logic               fire,
    output clwc_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    clwc_pkg::in_item_t item_reg;

    assign fire       = valid_reg && down_ready;
    assign s_tready   = !valid_reg || down_ready;
    assign valid_next = s_tready ? s_tvalid : valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

endmodule

[sv/clwc_core.sv]
module clwc_core #(
    parameter int PASS_LEN = clwc_pkg::PASS_LEN_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  clwc_pkg::cfg_wr_t  cfg,
    input  logic               step,
    input  clwc_pkg::in_item_t item,
    output clwc_pkg::result_t  result
);

    localparam int POS_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
    localparam int CNT_W = $clog2(PASS_LEN + 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PASS_LEN - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PASS_LEN);

    logic [clwc_pkg::MAX_WRONG_W-1:0]  max_wrong_reg;
    logic [clwc_pkg::IDLE_LIMIT_W-1:0] idle_limit_reg;

    logic [7:0] pass_reg  [PASS_LEN];
    logic [7:0] pass_next [PASS_LEN];
    logic [7:0] entry_reg  [PASS_LEN];
    logic [7:0] entry_next [PASS_LEN];

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [2:0]        miss_reg, miss_next;
    clwc_pkg::phase_t  phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       idle_reg, idle_next;
    clwc_pkg::event_t  ev;

    logic [7:0]  ch;
    logic        is_letter;
    logic [15:0] idle_inc;
    logic [2:0]  miss_inc;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        ch = item.byte_value;
        if (item.byte_value >= clwc_pkg::CH_UP_A && item.byte_value <= clwc_pkg::CH_UP_Z) begin
            ch = item.byte_value + clwc_pkg::CASE_OFFSET;
        end
    end

    assign is_letter = (ch >= clwc_pkg::CH_LO_A) && (ch <= clwc_pkg::CH_LO_Z);
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    // A stored strike count is at most six, so this never wraps.
    assign miss_inc  = miss_reg + 3'd1;
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    // Next state and event code for the transaction in the input register.
    always_comb begin
        pass_next  = pass_reg;
        entry_next = entry_reg;
        pos_next   = pos_reg;
        miss_next  = miss_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        idle_next  = idle_reg;
        ev         = clwc_pkg::EV_NONE;
        if (item.mode) begin
            if (phase_reg == clwc_pkg::PH_NORMAL) begin
                if (idle_limit_reg == '0) begin
                    idle_next = '0;
                end else begin
                    idle_next = idle_inc;
                    if (idle_inc >= idle_limit_reg) begin
                        idle_next = '0;
                        if (pos_reg != '0 || miss_reg != '0) begin
                            ev        = clwc_pkg::EV_IDLE;
                            pos_next  = '0;
                            miss_next = '0;
                        end
                    end
                end
            end
        end else begin
            idle_next = '0;
            case (phase_reg)
                clwc_pkg::PH_ENTER: begin
                    if (is_letter && cnt_reg < FULL_CNT) begin
                        entry_next[cnt_reg[POS_W-1:0]] = ch;
                        cnt_next = cnt_inc;
                        ev       = clwc_pkg::EV_STORED;
                        if (cnt_inc >= FULL_CNT) begin
                            phase_next = clwc_pkg::PH_CONFIRM;
                            ev         = clwc_pkg::EV_ASK;
                        end
                    end else if (ch == clwc_pkg::CH_CR || ch == clwc_pkg::CH_LF) begin
                        phase_next = clwc_pkg::PH_CONFIRM;
                        ev         = clwc_pkg::EV_ASK;
                    end
                end
                clwc_pkg::PH_CONFIRM: begin
                    if (ch == clwc_pkg::CH_Y) begin
                        pass_next  = entry_reg;
                        phase_next = clwc_pkg::PH_NORMAL;
                        ev         = clwc_pkg::EV_CHANGED;
                    end else if (ch == clwc_pkg::CH_N) begin
                        phase_next = clwc_pkg::PH_NORMAL;
                        ev         = clwc_pkg::EV_KEPT;
                    end
                end
                default: begin
                    if (ch == clwc_pkg::CH_PLUS) begin
                        for (int i = 0; i < PASS_LEN; i++) begin
                            entry_next[i] = 8'h00;
                        end
                        cnt_next   = '0;
                        phase_next = clwc_pkg::PH_ENTER;
                        ev         = clwc_pkg::EV_CHSTART;
                    end else if (is_letter) begin
                        if (ch != pass_reg[pos_reg]) begin
                            if (miss_inc >= max_wrong_reg) begin
                                ev        = clwc_pkg::EV_LOCKOUT;
                                pos_next  = '0;
                                miss_next = '0;
                            end else begin
                                ev        = clwc_pkg::EV_WRONG;
                                miss_next = miss_inc;
                            end
                        end else if (pos_reg == LAST_POS) begin
                            ev        = clwc_pkg::EV_UNLOCK;
                            pos_next  = '0;
                            miss_next = '0;
                        end else begin
                            ev       = clwc_pkg::EV_GOOD;
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    // Lamp and flash length follow from the event alone.
    always_comb begin
        result.event_res = ev;
        result.position  = 3'(32'(pos_next));
        result.strikes   = miss_next;
        result.phase_out = phase_next;
        case (ev)
            clwc_pkg::EV_GOOD: begin
                result.led      = clwc_pkg::LAMP_YELLOW;
                result.flash_ms = clwc_pkg::FLASH_SHORT;
            end
            clwc_pkg::EV_WRONG: begin
                result.led      = clwc_pkg::LAMP_RED;
                result.flash_ms = clwc_pkg::FLASH_SHORT;
            end
            clwc_pkg::EV_LOCKOUT: begin
                result.led      = clwc_pkg::LAMP_RED;
                result.flash_ms = clwc_pkg::FLASH_LONG;
            end
            clwc_pkg::EV_UNLOCK: begin
                result.led      = clwc_pkg::LAMP_GREEN;
                result.flash_ms = clwc_pkg::FLASH_LONG;
            end
            clwc_pkg::EV_IDLE: begin
                result.led      = clwc_pkg::LAMP_YELLOW;
                result.flash_ms = clwc_pkg::FLASH_MID;
            end
            default: begin
                result.led      = clwc_pkg::LAMP_NONE;
                result.flash_ms = clwc_pkg::FLASH_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_wrong_reg  <= clwc_pkg::MAX_WRONG_RESET;
            idle_limit_reg <= clwc_pkg::IDLE_LIMIT_RESET;
        end else if (cfg.wr_en) begin
            case (cfg.addr)
                clwc_pkg::CFG_MAX_WRONG: begin
                    max_wrong_reg <= cfg.wdata[clwc_pkg::MAX_WRONG_W-1:0];
                end
                clwc_pkg::CFG_IDLE_LIMIT: begin
                    idle_limit_reg <= cfg.wdata[clwc_pkg::IDLE_LIMIT_W-1:0];
                end
                default: begin
                    max_wrong_reg <= max_wrong_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PASS_LEN; i++) begin
                pass_reg[i]  <= clwc_pkg::default_char(i);
                entry_reg[i] <= 8'h00;
            end
            pos_reg   <= '0;
            miss_reg  <= '0;
            phase_reg <= clwc_pkg::PH_NORMAL;
            cnt_reg   <= '0;
            idle_reg  <= '0;
        end else if (step) begin
            pass_reg  <= pass_next;
            entry_reg <= entry_next;
            pos_reg   <= pos_next;
            miss_reg  <= miss_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

[sv/clwc_out_stage.sv]
module clwc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  clwc_pkg::result_t result,
    output logic              up_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output clwc_pkg::result_t m_result
);

    logic              valid_reg;
    logic              valid_next;
    clwc_pkg::result_t result_reg;

    assign up_ready   = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    assign m_tvalid   = valid_reg;
    assign m_result   = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

[sim/tb_code_lock_with_change.sv]
`timescale 1ns / 1ps

module tb_code_lock_with_change;

    localparam int CODE_LEN = clwc_pkg::PASS_LEN_DEFAULT;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;
    logic                            cfg_wr_en;
    logic [clwc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [clwc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    code_lock_with_change i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] byte_value
        .s_tuser   (s_tuser),   // [0] mode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [3:0] event_res, [5:4] led, [17:6] flash_ms, [20:18] position,
        // [23:21] strikes, [25:24] phase_out, [31:26] zero
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Mirror of the lock state, updated as each input transaction is accepted.
    logic [2:0]  lim_strikes;
    logic [15:0] lim_idle;
    logic [7:0]  code_mem [CODE_LEN];
    logic [7:0]  entry_mem [CODE_LEN];
    int unsigned match_pos;
    int unsigned miss_cnt;
    int unsigned entry_cnt;
    int unsigned idle_ticks;
    clwc_pkg::phase_t lock_phase;

    clwc_pkg::result_t pending_outcomes [$];
    int unsigned mismatch_cnt;
    int unsigned sent_items;
    bit          idling_on;
    int unsigned stall_left;

    // Works out what the lock reports for one character or tick and moves the
    // mirrored state on.
    function automatic clwc_pkg::result_t lock_outcome(input logic tick,
                                                       input logic [7:0] raw);
        clwc_pkg::result_t res;
        logic [7:0]  ch;
        logic        is_letter;
        int unsigned slot;
        res.event_res = clwc_pkg::EV_NONE;
        res.led       = clwc_pkg::LAMP_NONE;
        res.flash_ms  = clwc_pkg::FLASH_NONE;
        ch = raw;
        if (raw >= clwc_pkg::CH_UP_A && raw <= clwc_pkg::CH_UP_Z) begin
            ch = raw + clwc_pkg::CASE_OFFSET;
        end
        is_letter = (ch >= clwc_pkg::CH_LO_A) && (ch <= clwc_pkg::CH_LO_Z);
        if (tick) begin
            // Ticks only count while the lock is in its normal phase.
            if (lock_phase == clwc_pkg::PH_NORMAL) begin
                if (lim_idle == 16'd0) begin
                    idle_ticks = 0;
                end else begin
                    if (idle_ticks < 32'hFFFF) begin
                        idle_ticks++;
                    end
                    if (idle_ticks >= lim_idle) begin
                        idle_ticks = 0;
                        if (match_pos != 0 || miss_cnt != 0) begin
                            res.event_res = clwc_pkg::EV_IDLE;
                            res.led       = clwc_pkg::LAMP_YELLOW;
                            res.flash_ms  = clwc_pkg::FLASH_MID;
                            match_pos     = 0;
                            miss_cnt      = 0;
                        end
                    end
                end
            end
        end else begin
            idle_ticks = 0;
            case (lock_phase)
                clwc_pkg::PH_ENTER: begin
                    if (is_letter && entry_cnt < CODE_LEN) begin
                        entry_mem[entry_cnt] = ch;
                        entry_cnt++;
                        res.event_res = clwc_pkg::EV_STORED;
                        if (entry_cnt >= CODE_LEN) begin
                            lock_phase    = clwc_pkg::PH_CONFIRM;
                            res.event_res = clwc_pkg::EV_ASK;
                        end
                    end else if (ch == clwc_pkg::CH_CR || ch == clwc_pkg::CH_LF) begin
                        lock_phase    = clwc_pkg::PH_CONFIRM;
                        res.event_res = clwc_pkg::EV_ASK;
                    end
                end
                clwc_pkg::PH_CONFIRM: begin
                    if (ch == clwc_pkg::CH_Y) begin
                        code_mem      = entry_mem;
                        lock_phase    = clwc_pkg::PH_NORMAL;
                        res.event_res = clwc_pkg::EV_CHANGED;
                    end else if (ch == clwc_pkg::CH_N) begin
                        lock_phase    = clwc_pkg::PH_NORMAL;
                        res.event_res = clwc_pkg::EV_KEPT;
                    end
                end
                default: begin
                    if (ch == clwc_pkg::CH_PLUS) begin
                        foreach (entry_mem[i]) entry_mem[i] = 8'h00;
                        entry_cnt     = 0;
                        lock_phase    = clwc_pkg::PH_ENTER;
                        res.event_res = clwc_pkg::EV_CHSTART;
                    end else if (is_letter) begin
                        slot = (match_pos < CODE_LEN) ? match_pos : 0;
                        if (ch != code_mem[slot]) begin
                            miss_cnt++;
                            res.led = clwc_pkg::LAMP_RED;
                            if (miss_cnt >= lim_strikes) begin
                                res.event_res = clwc_pkg::EV_LOCKOUT;
                                res.flash_ms  = clwc_pkg::FLASH_LONG;
                                match_pos     = 0;
                                miss_cnt      = 0;
                            end else begin
                                res.event_res = clwc_pkg::EV_WRONG;
                                res.flash_ms  = clwc_pkg::FLASH_SHORT;
                            end
                        end else if (slot == CODE_LEN - 1) begin
                            res.event_res = clwc_pkg::EV_UNLOCK;
                            res.led       = clwc_pkg::LAMP_GREEN;
                            res.flash_ms  = clwc_pkg::FLASH_LONG;
                            match_pos     = 0;
                            miss_cnt      = 0;
                        end else begin
                            match_pos     = slot + 1;
                            res.event_res = clwc_pkg::EV_GOOD;
                            res.led       = clwc_pkg::LAMP_YELLOW;
                            res.flash_ms  = clwc_pkg::FLASH_SHORT;
                        end
                    end
                end
            endcase
        end
        res.position  = match_pos[2:0];
        res.strikes   = miss_cnt[2:0];
        res.phase_out = lock_phase;
        return res;
    endfunction

    function automatic logic [7:0] any_letter();
        return clwc_pkg::CH_LO_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] either_case(input logic [7:0] ch);
        if (ch >= clwc_pkg::CH_LO_A && ch <= clwc_pkg::CH_LO_Z
                && $urandom_range(0, 1) == 1) begin
            return ch - clwc_pkg::CASE_OFFSET;
        end
        return ch;
    endfunction

    // Offers one transaction, possibly after a burst of idle cycles, and
    // records the expected outcome once it has been accepted. The valid line
    // is left high so that back-to-back transactions need no extra edge.
    task automatic send_item(input logic tick, input logic [7:0] ch);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= tick;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        pending_outcomes.push_back(lock_outcome(tick, ch));
        sent_items++;
    endtask

    task automatic send_text(input string text);
        foreach (text[i]) send_item(1'b0, text[i]);
    endtask

    // Lowers valid and waits until every outcome has come back, then lets the
    // two register stages of the block settle.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input clwc_pkg::cfg_index_t idx,
                             input logic [clwc_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            clwc_pkg::CFG_MAX_WRONG:  lim_strikes = value[2:0];
            clwc_pkg::CFG_IDLE_LIMIT: lim_idle    = value[15:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic flag_field(input string field, input int unsigned want,
                              input int unsigned got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
        end
    endtask

    // Result side: random stalls in bursts while idling is on, and a check of
    // every transaction against the oldest outcome still waiting.
    initial begin
        clwc_pkg::result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    flag_field("unexpected result, tdata", 0, m_tdata);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_tdata[3:0] != want.event_res)
                        flag_field("event_res", want.event_res, m_tdata[3:0]);
                    if (m_tdata[5:4] != want.led)
                        flag_field("led", want.led, m_tdata[5:4]);
                    if (m_tdata[17:6] != want.flash_ms)
                        flag_field("flash_ms", want.flash_ms, m_tdata[17:6]);
                    if (m_tdata[20:18] != want.position)
                        flag_field("position", want.position, m_tdata[20:18]);
                    if (m_tdata[23:21] != want.strikes)
                        flag_field("strikes", want.strikes, m_tdata[23:21]);
                    if (m_tdata[25:24] != want.phase_out)
                        flag_field("phase_out", want.phase_out, m_tdata[25:24]);
                    if (m_tdata[31:26] != 6'd0)
                        flag_field("padding", 0, m_tdata[31:26]);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Letters against the factory password, stray bytes and a tick, ending in
    // a lockout at the reset strike limit of three.
    task automatic test_letters_and_strikes();
        send_item(1'b0, "A");
        send_item(1'b0, "x");
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, "Z");
        send_item(1'b0, "q");
    endtask

    // A short new password, which then can never be matched in full, followed
    // by a full-length one that moves to confirmation on its last letter, and
    // a change that is dropped.
    task automatic test_password_change();
        send_item(1'b0, clwc_pkg::CH_PLUS);
        send_item(1'b0, clwc_pkg::CH_PLUS);
        send_text("aB");
        send_item(1'b1, 8'h00);
        send_item(1'b0, clwc_pkg::CH_CR);
        send_item(1'b0, "q");
        send_item(1'b0, clwc_pkg::CH_Y);
        send_text("abc");
        send_item(1'b0, clwc_pkg::CH_PLUS);
        send_text("asdfghjk");
        send_item(1'b0, "Y");
        send_item(1'b0, clwc_pkg::CH_PLUS);
        send_item(1'b0, "k");
        send_item(1'b0, clwc_pkg::CH_LF);
        send_item(1'b0, "N");
    endtask

    task automatic test_strike_limits();
        settle_block();
        // Bits above the register width are dropped, leaving a limit of one.
        write_reg(clwc_pkg::CFG_MAX_WRONG, 16'hFFF9);
        send_item(1'b0, "x");
        settle_block();
        write_reg(clwc_pkg::CFG_MAX_WRONG, 16'd7);
        send_text("xxxx");
        settle_block();
        // Lowering the limit below the current count locks out on the next miss.
        write_reg(clwc_pkg::CFG_MAX_WRONG, 16'd2);
        send_item(1'b0, "x");
        settle_block();
        write_reg(clwc_pkg::CFG_MAX_WRONG, 16'd0);
        send_item(1'b0, "x");
        settle_block();
        write_reg(clwc_pkg::CFG_MAX_WRONG, 16'd3);
    endtask

    task automatic test_idle_timeout();
        settle_block();
        write_reg(clwc_pkg::CFG_IDLE_LIMIT, 16'd3);
        send_item(1'b0, "a");
        repeat (6) send_item(1'b1, 8'h00);
        settle_block();
        write_reg(clwc_pkg::CFG_IDLE_LIMIT, 16'd0);
        send_item(1'b0, "a");
        repeat (3) send_item(1'b1, 8'h00);
        settle_block();
        write_reg(clwc_pkg::CFG_IDLE_LIMIT, 16'd1);
        send_item(1'b1, 8'h00);
        settle_block();
        write_reg(clwc_pkg::CFG_IDLE_LIMIT, 16'hFFFF);
        send_item(1'b0, "a");
        repeat (2) send_item(1'b1, 8'h00);
        settle_block();
        write_reg(clwc_pkg::CFG_IDLE_LIMIT, clwc_pkg::IDLE_LIMIT_RESET);
    endtask

    // An attempt at the stored password in random case, sometimes cut short
    // or with one letter wrong.
    task automatic type_code();
        int unsigned stop_at;
        int unsigned bad_slot;
        stop_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CODE_LEN - 1) : CODE_LEN;
        bad_slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CODE_LEN - 1) : CODE_LEN;
        for (int i = 0; i < stop_at; i++) begin
            if (i == bad_slot) begin
                send_item(1'b0, either_case(any_letter()));
            end else if (code_mem[i] != 8'h00) begin
                send_item(1'b0, either_case(code_mem[i]));
            end
        end
    endtask

    // A password change, mostly full length, with stray characters mixed in.
    task automatic change_code();
        int unsigned count;
        count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, CODE_LEN - 1) : CODE_LEN;
        send_item(1'b0, clwc_pkg::CH_PLUS);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0) send_item(1'($urandom_range(0, 1)), 8'($urandom));
            send_item(1'b0, either_case(any_letter()));
        end
        if (count < CODE_LEN) begin
            send_item(1'b0, $urandom_range(0, 1) ? clwc_pkg::CH_CR : clwc_pkg::CH_LF);
        end
        if ($urandom_range(0, 3) == 0) send_item(1'($urandom_range(0, 1)), 8'($urandom));
        send_item(1'b0,
                  either_case(($urandom_range(0, 3) == 0) ? clwc_pkg::CH_N : clwc_pkg::CH_Y));
    endtask

    task automatic test_random_traffic(input int unsigned items_wanted, input bit with_idling);
        int unsigned stop_at;
        int unsigned chunk_end;
        stop_at = sent_items + items_wanted;
        while (sent_items < stop_at) begin
            settle_block();
            idling_on = with_idling;
            write_reg(clwc_pkg::CFG_MAX_WRONG, 16'($urandom_range(1, 7)));
            case ($urandom_range(0, 7))
                0: write_reg(clwc_pkg::CFG_IDLE_LIMIT, 16'd0);
                1: write_reg(clwc_pkg::CFG_IDLE_LIMIT,
                             $urandom_range(0, 1) ? 16'hFFFF : 16'd2000);
                default: write_reg(clwc_pkg::CFG_IDLE_LIMIT, 16'($urandom_range(1, 12)));
            endcase
            chunk_end = sent_items + 150;
            while (sent_items < chunk_end && sent_items < stop_at) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: type_code();
                    4, 5:       change_code();
                    6, 7:       repeat ($urandom_range(1, 12)) send_item(1'b1, 8'($urandom));
                    default:    send_item(1'($urandom_range(0, 1)), 8'($urandom));
                endcase
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        s_tuser    <= 1'b0;
        m_tready   <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_addr   <= clwc_pkg::CFG_MAX_WRONG;
        cfg_wdata  <= '0;
        lim_strikes = clwc_pkg::MAX_WRONG_RESET;
        lim_idle    = clwc_pkg::IDLE_LIMIT_RESET;
        foreach (code_mem[i]) code_mem[i] = clwc_pkg::default_char(i);
        foreach (entry_mem[i]) entry_mem[i] = 8'h00;
        match_pos    = 0;
        miss_cnt     = 0;
        entry_cnt    = 0;
        idle_ticks   = 0;
        lock_phase   = clwc_pkg::PH_NORMAL;
        mismatch_cnt = 0;
        sent_items   = 0;
        stall_left   = 0;
        idling_on    = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_letters_and_strikes();
        test_password_change();
        test_strike_limits();
        test_idle_timeout();
        test_random_traffic(1350, 1'b1);
        test_random_traffic(300, 1'b0);

        settle_block();
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0 && pending_outcomes.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of a few hundred microseconds.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
